/* design/mstdp_pkg.sv */
// ----------------------------------------------------------------------------
// mstdp_pkg
// Shared types and constants for the modulated STDP synapse updater: op
// codes, register indexes, register reset values and channel words.
// ----------------------------------------------------------------------------
`default_nettype none

package mstdp_pkg;

  // Op codes carried in the op field of an input word
  typedef enum logic [2:0] {
    OP_WINDOW_WRITE = 3'd0,
    OP_PRE_VISIT    = 3'd1,
    OP_POST_VISIT   = 3'd2,
    OP_RECORD_PRE   = 3'd3,
    OP_RECORD_POST  = 3'd4
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PLASTICITY_ENABLE = 2'd0,
    REG_MODULATION_GAIN   = 2'd1,
    REG_WEIGHT_LIMIT      = 2'd2
  } reg_idx_t;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // Register reset values
  localparam logic               PLASTICITY_ENABLE_RST = 1'b1;
  localparam logic signed [15:0] MODULATION_GAIN_RST   = 16'sd4096;
  localparam logic signed [15:0] WEIGHT_LIMIT_RST      = 16'sd32767;

  // Q3.12 rounding: half an output LSB in product units, and the shift back
  localparam logic signed [32:0] ROUND_HALF = 33'sd2048;
  localparam int                 FRAC_BITS  = 12;

  // Weight range
  localparam logic signed [21:0] WEIGHT_MAX = 22'sd32767;
  localparam logic signed [21:0] WEIGHT_MIN = -22'sd32768;

  // Input word
  typedef struct packed {
    logic        [2:0]  op;
    logic        [9:0]  neuron_index;
    logic signed [15:0] weight_in;
    logic        [31:0] now_time;
    logic               window_select;
    logic        [9:0]  window_index;
    logic signed [15:0] window_value;
  } in_item_t;

  // Result word
  typedef struct packed {
    logic signed [15:0] weight_out;
    logic signed [15:0] transmit_value;
    logic               transmit_valid;
    logic               saturated;
  } out_item_t;

  // Access request to the spike time store
  typedef struct packed {
    logic rd_en;
    logic pre_we;
    logic post_we;
  } spike_req_t;

endpackage

`default_nettype wire

/* design/mstdp_in_if.sv */
// ----------------------------------------------------------------------------
// mstdp_in_if
// Valid/ready channel carrying one input word of the STDP updater.
// ----------------------------------------------------------------------------
`default_nettype none

interface mstdp_in_if;
  logic                 valid;
  logic                 ready;
  mstdp_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/mstdp_out_if.sv */
// ----------------------------------------------------------------------------
// mstdp_out_if
// Valid/ready channel carrying one result word of the STDP updater.
// ----------------------------------------------------------------------------
`default_nettype none

interface mstdp_out_if;
  logic                  valid;
  logic                  ready;
  mstdp_pkg::out_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/mstdp_spike_store.sv */
// ----------------------------------------------------------------------------
// mstdp_spike_store
// Last spike time and seen flag of every pre and post neuron, one memory
// each. Entries are {seen, time}. After reset a clearing pass writes every
// entry with seen low, one entry a cycle; reads are registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mstdp_spike_store #(
  parameter  int NEURON_COUNT = 1024,
  parameter  int TIME_BITS    = 32,
  localparam int NAW          = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire mstdp_pkg::spike_req_t  req,
  input  wire logic [NAW-1:0]         addr,
  input  wire logic [TIME_BITS-1:0]   wr_time,
  output logic      [TIME_BITS:0]     pre_entry,
  output logic      [TIME_BITS:0]     post_entry,
  output logic                        clearing
);

  localparam logic [NAW-1:0] LAST_ADDR = NAW'(NEURON_COUNT - 1);

  logic [TIME_BITS:0] pre_mem_r  [NEURON_COUNT];
  logic [TIME_BITS:0] post_mem_r [NEURON_COUNT];
  logic [TIME_BITS:0] pre_rd_r;
  logic [TIME_BITS:0] post_rd_r;

  logic               clear_r;
  logic [NAW-1:0]     clear_cnt_r;

  logic [NAW-1:0]     wr_addr;
  logic [TIME_BITS:0] wr_word;
  logic               pre_wr;
  logic               post_wr;

  // Sweep every entry once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r     <= 1'b1;
      clear_cnt_r <= '0;
    end else if (clear_r) begin
      if (clear_cnt_r == LAST_ADDR) begin
        clear_r <= 1'b0;
      end else begin
        clear_cnt_r <= clear_cnt_r + NAW'(1);
      end
    end
  end

  // Pick the clearing pass or a spike record for the write port
  always_comb begin
    wr_addr = clear_r ? clear_cnt_r : addr;
    wr_word = clear_r ? '0 : {1'b1, wr_time};
    pre_wr  = clear_r || req.pre_we;
    post_wr = clear_r || req.post_we;
  end

  // Write and registered read, one port each
  always_ff @(posedge clk) begin
    if (pre_wr) begin
      pre_mem_r[wr_addr] <= wr_word;
    end
    if (post_wr) begin
      post_mem_r[wr_addr] <= wr_word;
    end
    if (req.rd_en) begin
      pre_rd_r  <= pre_mem_r[addr];
      post_rd_r <= post_mem_r[addr];
    end
  end

  assign pre_entry  = pre_rd_r;
  assign post_entry = post_rd_r;
  assign clearing   = clear_r;

endmodule

`default_nettype wire

/* design/modulated_stdp_synapse_update.sv */
// ----------------------------------------------------------------------------
// modulated_stdp_synapse_update
// Event-driven pair STDP weight updater with modulated, table-driven windows.
// ----------------------------------------------------------------------------
// The block takes one word per clock unless stalled or clearing; each word
// gives exactly one result. There are four register stages: spike time read,
// window read, gain multiply, round and saturate into the output register.
// Every memory has one write and one read port and is touched once per word,
// so a new word enters each cycle while results drain, and a stalled output
// only holds the words ahead of the first empty stage. After reset the spike
// time store runs a clearing pass over all NEURON_COUNT entries (1024 by
// default) during which in_ch.ready is low; configuration writes are taken
// during it. The user must change configuration only while no word is in
// flight; the block does not enforce this. Window entries must be written
// before a visit uses them; unwritten entries read as unknown values.
// ----------------------------------------------------------------------------
`default_nettype none

module modulated_stdp_synapse_update #(
  parameter int WINDOW_DEPTH = 1024,
  parameter int NEURON_COUNT = 1024,
  parameter int TIME_BITS    = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  mstdp_in_if.sink                                  in_ch,
  mstdp_out_if.source                               out_ch,
  input  wire logic                                 cfg_we,
  input  wire logic [mstdp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [mstdp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int WAW = $clog2(WINDOW_DEPTH);
  localparam int NAW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
  localparam int CW  = (TIME_BITS > 17) ? TIME_BITS : 17;
  localparam int RW  = 21;

  localparam logic [WAW-1:0] FLOOR_IDX   = WAW'(WINDOW_DEPTH - 1);
  localparam logic [CW-1:0]  FLOOR_DIFF  = CW'(WINDOW_DEPTH - 1);
  localparam logic [16:0]    WIN_LIMIT   = 17'(WINDOW_DEPTH);
  localparam logic [RW-1:0]  NEURON_LIM  = RW'(NEURON_COUNT);

  // Configuration registers
  logic               plast_en_r;
  logic signed [15:0] gain_r;
  logic signed [15:0] limit_r;

  // Handshake
  logic ld_o, ld3, ld2, ld1;
  logic in_fire;
  logic clearing;

  // Stage 1: input word with spike store entries
  logic                 v1_r;
  mstdp_pkg::in_item_t  s1_item_r;
  logic                 s1_inr_r;
  logic                 in_range;
  logic [TIME_BITS:0]   pre_entry;
  logic [TIME_BITS:0]   post_entry;
  logic [TIME_BITS:0]   s1_entry;
  logic [TIME_BITS-1:0] s1_now;
  logic [TIME_BITS-1:0] s1_diff;
  logic                 s1_far;
  logic [WAW-1:0]       s1_slot;
  logic                 s1_apply;
  logic                 win_we;
  mstdp_pkg::spike_req_t spike_req;

  // Window tables
  logic signed [15:0] win_pot_r [WINDOW_DEPTH];
  logic signed [15:0] win_dep_r [WINDOW_DEPTH];
  logic signed [15:0] pot_rd_r;
  logic signed [15:0] dep_rd_r;

  // Stage 2: window value
  logic               v2_r;
  logic [2:0]         s2_op_r;
  logic signed [15:0] s2_w_r;
  logic               s2_apply_r;
  logic signed [15:0] s2_win;

  // Stage 3: scaled product
  logic               v3_r;
  logic [2:0]         s3_op_r;
  logic signed [15:0] s3_w_r;
  logic               s3_apply_r;
  logic signed [31:0] s3_prod_r;
  logic signed [32:0] s3_rnd;
  logic signed [RW-1:0] s3_dw;
  logic signed [21:0] s3_sum;
  mstdp_pkg::out_item_t s3_res;

  // Output register
  logic                 out_v_r;
  mstdp_pkg::out_item_t out_item_r;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plast_en_r <= mstdp_pkg::PLASTICITY_ENABLE_RST;
      gain_r     <= mstdp_pkg::MODULATION_GAIN_RST;
      limit_r    <= mstdp_pkg::WEIGHT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mstdp_pkg::REG_PLASTICITY_ENABLE: plast_en_r <= cfg_wdata[0];
        mstdp_pkg::REG_MODULATION_GAIN:   gain_r     <= $signed(cfg_wdata);
        mstdp_pkg::REG_WEIGHT_LIMIT:      limit_r    <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Advance each stage when the next one is empty or moving
  always_comb begin
    ld_o    = !out_v_r || out_ch.ready;
    ld3     = !v3_r || ld_o;
    ld2     = !v2_r || ld3;
    ld1     = !v1_r || ld2;
    in_fire = in_ch.valid && ld1 && !clearing;
  end

  assign in_ch.ready = ld1 && !clearing;

  // Record spikes and read the partner's entries as the word enters
  assign in_range = RW'(in_ch.data.neuron_index) < NEURON_LIM;

  always_comb begin
    spike_req.rd_en   = in_fire;
    spike_req.pre_we  = in_fire && in_range &&
                        (in_ch.data.op == mstdp_pkg::OP_RECORD_PRE);
    spike_req.post_we = in_fire && in_range &&
                        (in_ch.data.op == mstdp_pkg::OP_RECORD_POST);
  end

  mstdp_spike_store #(
    .NEURON_COUNT (NEURON_COUNT),
    .TIME_BITS    (TIME_BITS)
  ) u_spike_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (spike_req),
    .addr       (NAW'(in_ch.data.neuron_index)),
    .wr_time    (TIME_BITS'(in_ch.data.now_time)),
    .pre_entry  (pre_entry),
    .post_entry (post_entry),
    .clearing   (clearing)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ld1) begin
      v1_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_ch.data;
      s1_inr_r  <= in_range;
    end
  end

  // Clamp the time since the partner's last spike to the window
  always_comb begin
    s1_entry = (s1_item_r.op == mstdp_pkg::OP_PRE_VISIT) ? post_entry : pre_entry;
    s1_now   = TIME_BITS'(s1_item_r.now_time);
    s1_diff  = s1_now - s1_entry[TIME_BITS-1:0];
    s1_far   = CW'(s1_diff) >= FLOOR_DIFF;
    s1_slot  = (!s1_inr_r || !s1_entry[TIME_BITS] || s1_far) ? FLOOR_IDX
                                                              : WAW'(s1_diff);
    s1_apply = plast_en_r &&
               ((s1_item_r.op == mstdp_pkg::OP_PRE_VISIT) ||
                ((s1_item_r.op == mstdp_pkg::OP_POST_VISIT) &&
                 (s1_item_r.weight_in < limit_r)));
    win_we   = v1_r && ld2 && (s1_item_r.op == mstdp_pkg::OP_WINDOW_WRITE) &&
               (17'(s1_item_r.window_index) < WIN_LIMIT);
  end

  // Load window entries and read both tables at the slot
  always_ff @(posedge clk) begin
    if (win_we) begin
      if (s1_item_r.window_select) begin
        win_dep_r[WAW'(s1_item_r.window_index)] <= s1_item_r.window_value;
      end else begin
        win_pot_r[WAW'(s1_item_r.window_index)] <= s1_item_r.window_value;
      end
    end
    if (ld2) begin
      pot_rd_r <= win_pot_r[s1_slot];
      dep_rd_r <= win_dep_r[s1_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ld2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_op_r    <= s1_item_r.op;
      s2_w_r     <= s1_item_r.weight_in;
      s2_apply_r <= s1_apply;
    end
  end

  // Pre visits depress, post visits potentiate
  assign s2_win = (s2_op_r == mstdp_pkg::OP_PRE_VISIT) ? dep_rd_r : pot_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (ld3) begin
      v3_r <= v2_r;
    end
  end

  // Scale the window value by the modulation gain
  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_op_r    <= s2_op_r;
      s3_w_r     <= s2_w_r;
      s3_apply_r <= s2_apply_r;
      s3_prod_r  <= gain_r * s2_win;
    end
  end

  // Round half up, add to the weight and saturate
  always_comb begin
    s3_rnd = 33'(s3_prod_r) + mstdp_pkg::ROUND_HALF;
    s3_dw  = RW'(s3_rnd >>> mstdp_pkg::FRAC_BITS);
    s3_sum = 22'(s3_w_r) + 22'(s3_dw);

    s3_res.weight_out     = s3_w_r;
    s3_res.saturated      = 1'b0;
    s3_res.transmit_valid = (s3_op_r == mstdp_pkg::OP_PRE_VISIT);
    s3_res.transmit_value = s3_res.transmit_valid ? s3_w_r : 16'sd0;
    if (s3_apply_r) begin
      priority if (s3_sum > mstdp_pkg::WEIGHT_MAX) begin
        s3_res.weight_out = 16'sd32767;
        s3_res.saturated  = 1'b1;
      end else if (s3_sum < mstdp_pkg::WEIGHT_MIN) begin
        s3_res.weight_out = -16'sd32768;
        s3_res.saturated  = 1'b1;
      end else begin
        s3_res.weight_out = 16'(s3_sum);
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (ld_o) begin
      out_v_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_o) begin
      out_item_r <= s3_res;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_item_r;

endmodule

`default_nettype wire

/* tb/tb_modulated_stdp_synapse_update.sv */
// ----------------------------------------------------------------------------
// tb_modulated_stdp_synapse_update
// Self-checking bench for the modulated STDP synapse updater. Loads the low
// and high ends of both window tables, walks a short directed table of edge
// cases, then streams random spike records, synapse visits and table writes
// under several register settings and idling patterns. Visits are timed so
// they land on loaded window entries or past the floor. Every result word is
// checked against the directed table's expected word or an in-bench model of
// spike times, windows and the saturating weight update.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_modulated_stdp_synapse_update;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF       = 4;
  localparam int NEURONS        = 1024;
  localparam int WINDOW_SIZE    = 1024;
  localparam int WINDOW_FLOOR   = WINDOW_SIZE - 1;
  localparam int LOAD_LOW       = 192;
  localparam int LOAD_HIGH      = 64;
  localparam int SEGMENTS       = 6;
  localparam int SEGMENT_WORDS  = 160;
  localparam int SETTLE_CYCLES  = 8;
  localparam int STALL_LIMIT    = 10000;
  localparam int REPORT_LIMIT   = 10;

  // Op codes the block leaves without effect
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // Window table select
  localparam logic SEL_POTENTIATION = 1'b0;
  localparam logic SEL_DEPRESSION   = 1'b1;

  localparam logic [15:0] W_MAX = 16'h7FFF;
  localparam logic [15:0] W_MIN = 16'h8000;

  typedef struct {
    mstdp_pkg::in_item_t  word;
    bit                   typed;
    mstdp_pkg::out_item_t result;
  } directed_row_t;

  typedef struct {
    logic               enable;
    logic signed [15:0] gain;
    logic signed [15:0] limit;
  } plasticity_setting_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [mstdp_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [mstdp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;

  mstdp_in_if  in_ch ();
  mstdp_out_if out_ch ();

  modulated_stdp_synapse_update #(
    .WINDOW_DEPTH (WINDOW_SIZE),
    .NEURON_COUNT (NEURONS),
    .TIME_BITS    (32)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // Model state: spike times, windows and registers
  logic [31:0]        pre_time [NEURONS];
  bit                 pre_seen [NEURONS];
  logic [31:0]        post_time [NEURONS];
  bit                 post_seen [NEURONS];
  logic signed [15:0] potentiation_win [WINDOW_SIZE];
  logic signed [15:0] depression_win [WINDOW_SIZE];
  logic               plasticity_on = mstdp_pkg::PLASTICITY_ENABLE_RST;
  logic signed [15:0] gain_q12      = mstdp_pkg::MODULATION_GAIN_RST;
  logic signed [15:0] limit_q12     = mstdp_pkg::WEIGHT_LIMIT_RST;

  mstdp_pkg::out_item_t pending_results [$];
  directed_row_t        directed_rows [$];
  int                   mismatch_count = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   stall_cycles = 0;

  // Compute the result word for one accepted input word and advance the model
  function automatic mstdp_pkg::out_item_t update_synapse(input mstdp_pkg::in_item_t word);
    logic signed [15:0]   w_cur;
    logic signed [15:0]   w_tab;
    logic [31:0]          last;
    logic [31:0]          elapsed;
    bit                   seen;
    bit                   visit;
    int                   slot;
    int                   sum;
    longint               prod;
    mstdp_pkg::out_item_t res;
    w_cur = word.weight_in;
    res.weight_out     = w_cur;
    res.transmit_value = '0;
    res.transmit_valid = 1'b0;
    res.saturated      = 1'b0;
    visit = 1'b0;
    seen  = 1'b0;
    last  = '0;
    case (word.op)
      mstdp_pkg::OP_WINDOW_WRITE: begin
        if (word.window_select == SEL_DEPRESSION)
          depression_win[word.window_index] = word.window_value;
        else
          potentiation_win[word.window_index] = word.window_value;
      end
      mstdp_pkg::OP_PRE_VISIT: begin
        res.transmit_value = w_cur;
        res.transmit_valid = 1'b1;
        if (plasticity_on) begin
          seen  = post_seen[word.neuron_index];
          last  = post_time[word.neuron_index];
          visit = 1'b1;
        end
      end
      mstdp_pkg::OP_POST_VISIT: begin
        if (plasticity_on && w_cur < limit_q12) begin
          seen  = pre_seen[word.neuron_index];
          last  = pre_time[word.neuron_index];
          visit = 1'b1;
        end
      end
      mstdp_pkg::OP_RECORD_PRE: begin
        pre_time[word.neuron_index] = word.now_time;
        pre_seen[word.neuron_index] = 1'b1;
      end
      mstdp_pkg::OP_RECORD_POST: begin
        post_time[word.neuron_index] = word.now_time;
        post_seen[word.neuron_index] = 1'b1;
      end
      default: ;
    endcase
    if (visit) begin
      // Clamp elapsed time to the floor entry; a never-seen partner uses it too
      elapsed = word.now_time - last;
      slot = (!seen || elapsed >= 32'(WINDOW_FLOOR)) ? WINDOW_FLOOR : int'(elapsed);
      w_tab = (word.op == mstdp_pkg::OP_PRE_VISIT) ? depression_win[slot]
                                                   : potentiation_win[slot];
      prod = longint'(gain_q12) * longint'(w_tab) + 64'sd2048;
      sum = int'(w_cur) + int'(prod >>> mstdp_pkg::FRAC_BITS);
      if (sum > 32767) begin
        sum = 32767;
        res.saturated = 1'b1;
      end else if (sum < -32768) begin
        sum = -32768;
        res.saturated = 1'b1;
      end
      res.weight_out = 16'(sum);
    end
    return res;
  endfunction

  function automatic mstdp_pkg::in_item_t word_of(input logic [2:0] op,
                                                  input logic [9:0] neuron,
                                                  input logic [15:0] weight,
                                                  input logic [31:0] now,
                                                  input logic sel, input logic [9:0] idx,
                                                  input logic [15:0] val);
    mstdp_pkg::in_item_t w;
    w.op            = op;
    w.neuron_index  = neuron;
    w.weight_in     = weight;
    w.now_time      = now;
    w.window_select = sel;
    w.window_index  = idx;
    w.window_value  = val;
    return w;
  endfunction

  function automatic mstdp_pkg::out_item_t result_of(input logic [15:0] weight,
                                                     input logic [15:0] tx,
                                                     input logic tv, input logic sat);
    mstdp_pkg::out_item_t r;
    r.weight_out     = weight;
    r.transmit_value = tx;
    r.transmit_valid = tv;
    r.saturated      = sat;
    return r;
  endfunction

  // Offer one word, hold it until taken, then queue its expected result
  task automatic push_word(input mstdp_pkg::in_item_t word, input bit typed,
                           input mstdp_pkg::out_item_t typed_result);
    mstdp_pkg::out_item_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= word;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predicted = update_synapse(word);
    pending_results.push_back(typed ? typed_result : predicted);
    @(negedge clk);
  endtask

  // Hold the sender until every expected result word has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input mstdp_pkg::reg_idx_t idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic apply_setting(input plasticity_setting_t s);
    write_reg(mstdp_pkg::REG_PLASTICITY_ENABLE, {15'd0, s.enable});
    write_reg(mstdp_pkg::REG_MODULATION_GAIN, s.gain);
    write_reg(mstdp_pkg::REG_WEIGHT_LIMIT, s.limit);
    cfg_we <= 1'b0;
    plasticity_on = s.enable;
    gain_q12      = s.gain;
    limit_q12     = s.limit;
  endtask

  // Receiver: drop ready at random
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    mstdp_pkg::out_item_t exp_r;
    mstdp_pkg::out_item_t act_r;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      act_r = out_ch.data;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("[%0t] unexpected result word: w=%0d tx=%0d tv=%0b sat=%0b", $realtime,
                   act_r.weight_out, act_r.transmit_value, act_r.transmit_valid,
                   act_r.saturated);
      end else begin
        exp_r = pending_results.pop_front();
        if (act_r.weight_out !== exp_r.weight_out ||
            act_r.transmit_value !== exp_r.transmit_value ||
            act_r.transmit_valid !== exp_r.transmit_valid ||
            act_r.saturated !== exp_r.saturated) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: expected w=%0d tx=%0d tv=%0b sat=%0b",
                     $realtime, exp_r.weight_out, exp_r.transmit_value,
                     exp_r.transmit_valid, exp_r.saturated);
            $display("[%0t]           actual   w=%0d tx=%0d tv=%0b sat=%0b",
                     $realtime, act_r.weight_out, act_r.transmit_value,
                     act_r.transmit_valid, act_r.saturated);
          end
        end
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int                  seg;
    int                  k;
    int                  r;
    int                  tr;
    int                  dr;
    int                  load_idx;
    bit                  partner_seen;
    logic [31:0]         partner_time;
    logic [31:0]         gap;
    mstdp_pkg::in_item_t word;
    logic [31:0]         time_cursor;
    plasticity_setting_t seg_cfg [SEGMENTS];

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;

    // Directed table: extremes, every op, floor and wrap cases
    directed_rows.push_back('{word_of(mstdp_pkg::OP_WINDOW_WRITE, 10'd0, 16'h1234, 32'd0,
                            SEL_DEPRESSION, 10'd1023, W_MAX), 1'b1,
                            result_of(16'h1234, 16'h0, 1'b0, 1'b0)});
    directed_rows.push_back('{word_of(mstdp_pkg::OP_WINDOW_WRITE, 10'd0, 16'hEDCB, 32'd0,
                            SEL_POTENTIATION, 10'd1023, W_MIN), 1'b1,
                            result_of(16'hEDCB, 16'h0, 1'b0, 1'b0)});
    directed_rows.push_back('{word_of(mstdp_pkg::OP_WINDOW_WRITE, 10'd0, 16'h0000, 32'd0,
                            SEL_POTENTIATION, 10'd0, W_MAX), 1'b1,
                            result_of(16'h0000, 16'h0, 1'b0, 1'b0)});
    directed_rows.push_back('{word_of(mstdp_pkg::OP_WINDOW_WRITE, 10'd0, 16'hFFFF, 32'd0,
                            SEL_DEPRESSION, 10'd0, W_MIN), 1'b1,
                            result_of(16'hFFFF, 16'h0, 1'b0, 1'b0)});
    // Never-spiked partner takes the floor entry and clips
    directed_rows.push_back('{word_of(mstdp_pkg::OP_PRE_VISIT, 10'd5, W_MAX, 32'd0, 1'b0,
                            10'd0, 16'h0), 1'b1, result_of(W_MAX, W_MAX, 1'b1, 1'b1)});
    directed_rows.push_back('{word_of(mstdp_pkg::OP_POST_VISIT, 10'd5, W_MIN, 32'd0, 1'b0,
                            10'd0, 16'h0), 1'b1, result_of(W_MIN, 16'h0, 1'b0, 1'b1)});
    // Weight at the limit: no potentiation
    directed_rows.push_back('{word_of(mstdp_pkg::OP_POST_VISIT, 10'd5, W_MAX, 32'd0, 1'b0,
                            10'd0, 16'h0), 1'b1, result_of(W_MAX, 16'h0, 1'b0, 1'b0)});
    directed_rows.push_back('{word_of(mstdp_pkg::OP_RECORD_PRE, 10'd0, 16'hFFFF,
                            32'hFFFF_FFF0, 1'b0, 10'd0, 16'h0), 1'b1,
                            result_of(16'hFFFF, 16'h0, 1'b0, 1'b0)});
    directed_rows.push_back('{word_of(mstdp_pkg::OP_RECORD_POST, 10'd1023, W_MIN, 32'd100,
                            1'b0, 10'd0, 16'h0), 1'b1, result_of(W_MIN, 16'h0, 1'b0, 1'b0)});
    directed_rows.push_back('{word_of(mstdp_pkg::OP_RECORD_POST, 10'd0, W_MAX, 32'd0, 1'b0,
                            10'd0, 16'h0), 1'b1, result_of(W_MAX, 16'h0, 1'b0, 1'b0)});
    directed_rows.push_back('{word_of(mstdp_pkg::OP_POST_VISIT, 10'd0, 16'h0000,
                            32'hFFFF_FFF0, 1'b0, 10'd0, 16'h0), 1'b0, '0});
    // Elapsed zero, one below the floor, at the floor, and in the future
    directed_rows.push_back('{word_of(mstdp_pkg::OP_PRE_VISIT, 10'd1023, W_MIN, 32'd100,
                            1'b0, 10'd0, 16'h0), 1'b0, '0});
    directed_rows.push_back('{word_of(mstdp_pkg::OP_PRE_VISIT, 10'd1023, 16'h0000, 32'd1122,
                            1'b0, 10'd0, 16'h0), 1'b0, '0});
    directed_rows.push_back('{word_of(mstdp_pkg::OP_PRE_VISIT, 10'd1023, 16'h0000, 32'd1123,
                            1'b0, 10'd0, 16'h0), 1'b0, '0});
    directed_rows.push_back('{word_of(mstdp_pkg::OP_PRE_VISIT, 10'd1023, 16'd1000, 32'd50,
                            1'b0, 10'd0, 16'h0), 1'b0, '0});
    // Elapsed time across the 32-bit wrap
    directed_rows.push_back('{word_of(mstdp_pkg::OP_POST_VISIT, 10'd0, 16'h0000, 32'd5,
                            1'b0, 10'd0, 16'h0), 1'b0, '0});
    directed_rows.push_back('{word_of(mstdp_pkg::OP_POST_VISIT, 10'd0, 16'hFFFF,
                            32'hFFFF_FFFF, 1'b0, 10'd0, 16'h0), 1'b0, '0});
    // Spare op codes pass the weight through
    directed_rows.push_back('{word_of(OP_SPARE_5, 10'h3FF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                            10'h3FF, 16'hFFFF), 1'b1, result_of(16'hFFFF, 16'h0, 1'b0, 1'b0)});
    directed_rows.push_back('{word_of(OP_SPARE_6, 10'd0, 16'h0000, 32'd0, 1'b0, 10'd0, 16'h0),
                            1'b1, result_of(16'h0000, 16'h0, 1'b0, 1'b0)});
    directed_rows.push_back('{word_of(OP_SPARE_7, 10'd7, W_MIN, 32'd9, 1'b1, 10'd3, W_MAX),
                            1'b1, result_of(W_MIN, 16'h0, 1'b0, 1'b0)});
    directed_rows.push_back('{word_of(mstdp_pkg::OP_RECORD_PRE, 10'd1023, 16'h0001,
                            32'hFFFF_FFFF, 1'b0, 10'd0, 16'h0), 1'b1,
                            result_of(16'h0001, 16'h0, 1'b0, 1'b0)});
    directed_rows.push_back('{word_of(mstdp_pkg::OP_POST_VISIT, 10'd1023, 16'h7FFE,
                            32'hFFFF_FFFF, 1'b0, 10'd0, 16'h0), 1'b0, '0});
    directed_rows.push_back('{word_of(mstdp_pkg::OP_PRE_VISIT, 10'd512, 16'h0000, 32'd0,
                            1'b0, 10'd0, 16'h0), 1'b0, '0});

    seg_cfg[0] = '{1'b1, 16'sh7FFF, 16'sh7FFF};
    seg_cfg[1] = '{1'b1, 16'sh8000, 16'sh8000};
    seg_cfg[2] = '{1'b1, 16'($urandom), 16'($urandom)};
    seg_cfg[3] = '{1'b0, 16'sh1000, 16'sh7FFF};
    seg_cfg[4] = '{1'b1, 16'sh0000, 16'sh0000};
    seg_cfg[5] = '{1'b1, 16'($urandom), 16'($urandom)};

    // Reset, then program the reset values during the clearing pass
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    apply_setting('{mstdp_pkg::PLASTICITY_ENABLE_RST, mstdp_pkg::MODULATION_GAIN_RST,
                    mstdp_pkg::WEIGHT_LIMIT_RST});

    send_idle_pct = 28;
    recv_idle_pct = 88;

    // Load the low and high ends of both window tables
    for (k = 0; k < 2 * (LOAD_LOW + LOAD_HIGH); k++) begin
      load_idx = k >> 1;
      if (load_idx >= LOAD_LOW)
        load_idx = load_idx + WINDOW_SIZE - LOAD_HIGH - LOAD_LOW;
      word = word_of(mstdp_pkg::OP_WINDOW_WRITE, 10'($urandom), 16'($urandom), $urandom,
                     k[0] ? SEL_DEPRESSION : SEL_POTENTIATION, 10'(load_idx),
                     16'($urandom));
      push_word(word, 1'b0, '0);
    end

    foreach (directed_rows[i])
      push_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);

    // Random segments, each under its own register setting
    time_cursor = $urandom;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      drain_results();
      apply_setting(seg_cfg[seg]);
      case (seg / 2)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (k = 0; k < SEGMENT_WORDS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 10)      word.op = mstdp_pkg::OP_WINDOW_WRITE;
        else if (r < 40) word.op = mstdp_pkg::OP_PRE_VISIT;
        else if (r < 70) word.op = mstdp_pkg::OP_POST_VISIT;
        else if (r < 82) word.op = mstdp_pkg::OP_RECORD_PRE;
        else if (r < 94) word.op = mstdp_pkg::OP_RECORD_POST;
        else             word.op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
        // Mostly a small neuron pool so visits find recorded partners
        word.neuron_index = ($urandom_range(0, 9) == 0) ? 10'($urandom)
                                                        : 10'($urandom_range(0, 15));
        // Advance a time cursor; jump now and then to reach the floor and wrap
        tr = $urandom_range(0, 99);
        if (tr < 4)      time_cursor = $urandom;
        else if (tr < 8) time_cursor = time_cursor + 32'($urandom_range(900, 1100));
        else             time_cursor = time_cursor + 32'($urandom_range(0, 5));
        word.now_time = time_cursor;
        if (tr >= 96)      word.now_time = $urandom;
        else if (tr >= 92) word.now_time = time_cursor - 32'($urandom_range(1, 30));
        word.weight_in     = 16'($urandom);
        word.window_select = 1'($urandom);
        word.window_index  = 10'($urandom);
        word.window_value  = 16'($urandom);
        // Time visits so they land on loaded entries, past the floor or in the future
        if (word.op == mstdp_pkg::OP_PRE_VISIT || word.op == mstdp_pkg::OP_POST_VISIT) begin
          if (word.op == mstdp_pkg::OP_PRE_VISIT) begin
            partner_seen = post_seen[word.neuron_index];
            partner_time = post_time[word.neuron_index];
          end else begin
            partner_seen = pre_seen[word.neuron_index];
            partner_time = pre_time[word.neuron_index];
          end
          if (partner_seen) begin
            dr = $urandom_range(0, 99);
            if (dr < 70)
              gap = 32'($urandom_range(0, LOAD_LOW - 1));
            else if (dr < 85)
              gap = 32'($urandom_range(WINDOW_SIZE - LOAD_HIGH, WINDOW_FLOOR + 4));
            else if (dr < 95)
              gap = 32'($urandom_range(WINDOW_SIZE, 1 << 20));
            else
              gap = -32'($urandom_range(1, 30));
            word.now_time = partner_time + gap;
          end
        end
        push_word(word, 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
